FILE: rtl/cafu_pkg.sv
// Shared types and constants of the 8-bit arithmetic and flag unit.
`timescale 1ns / 1ps

package cafu_pkg;

   // Operation codes of the request channel.
   typedef enum logic [3:0] {
      CMD_ADC = 4'd0,
      CMD_SBC = 4'd1,
      CMD_CMP = 4'd2,
      CMD_CPX = 4'd3,
      CMD_CPY = 4'd4,
      CMD_ANC = 4'd5,
      CMD_ARR = 4'd6,
      CMD_ASR = 4'd7,
      CMD_SBX = 4'd8,
      CMD_DCP = 4'd9,
      CMD_ISC = 4'd10,
      CMD_RLA = 4'd11,
      CMD_RRA = 4'd12,
      CMD_SLO = 4'd13,
      CMD_SRE = 4'd14
   } cmd_type;

   // Destination register codes.
   typedef enum logic [1:0] {
      TGT_NONE = 2'd0,
      TGT_ACC  = 2'd1,
      TGT_X    = 2'd2
   } tgt_type;

   // Flag mask bits: N, Z, C, V from the top down.
   localparam int unsigned MASK_BIT_N = 3;
   localparam int unsigned MASK_BIT_Z = 2;
   localparam int unsigned MASK_BIT_C = 1;
   localparam int unsigned MASK_BIT_V = 0;

   localparam logic [3:0] MASK_NONE = 4'b0000;
   localparam logic [3:0] MASK_NZ   = 4'b1100;
   localparam logic [3:0] MASK_NZC  = 4'b1110;
   localparam logic [3:0] MASK_NZCV = 4'b1111;

   // BCD constants.
   localparam logic [4:0] BCD_LIMIT  = 5'd10;
   localparam logic [4:0] BCD_ADJ5   = 5'd6;
   localparam logic [5:0] BCD_ADJ6   = 6'd6;
   localparam logic [7:0] BCD_HI_ADJ = 8'h60;

   // Output of the decode stage.
   typedef struct packed {
      logic [7:0] alu_a;
      logic [7:0] alu_b;
      logic       alu_cin;
      logic       dec;
      logic       sub;
      logic       use_alu;
      logic [7:0] logic_val;
      logic       logic_c;
      tgt_type    tgt;
      logic [7:0] mem_val;
      logic       mem_wr;
      logic [3:0] mask;
      logic       cin_orig;
   } prep_type;

   // Output of the adder stage.
   typedef struct packed {
      logic [8:0] bin;
      logic       v_bin;
      logic       x7;
      logic       y7;
      logic [4:0] lo_sum;
      logic [4:0] hi_sum;
      logic [5:0] lo_diff;
      logic [9:0] hi_diff;
      logic       dec;
      logic       sub;
      logic       use_alu;
      logic [7:0] logic_val;
      logic       logic_c;
      tgt_type    tgt;
      logic [7:0] mem_val;
      logic       mem_wr;
      logic [3:0] mask;
      logic       cin_orig;
   } sum_type;

   // Finished result.
   typedef struct packed {
      logic [7:0] reg_value;
      tgt_type    reg_target;
      logic [7:0] mem_value;
      logic       mem_write;
      logic       flag_n;
      logic       flag_z;
      logic       flag_c;
      logic       flag_v;
      logic [3:0] flag_mask;
   } result_type;

endpackage

FILE: rtl/cpu8_arith_flag_unit.sv
// Top level of the 8-bit arithmetic and flag unit: three-stage pipeline.
//
//   Channel   Direction   Handshake            Payload
//   req_      in          req_valid/req_stall  cmd, acc, X, Y, operand, carry, decimal
//   rsp_      out         rsp_valid/rsp_stall  register value and target, memory byte,
//                                              N Z C V flags and flag mask
//
// Every request transfer yields exactly one response transfer, passing the decode, adder
// and flag registers. A new request may be transferred in every cycle without req_stall.
// The three stages are decode, adder and flag fix-up, each ending in a register.
// Reset is synchronous and active high; it clears the valid bits of all three stages.
// A stall holds each occupied stage in place; empty stages further up still fill, so
// the pipeline compresses bubbles while the response waits.
`timescale 1ns / 1ps

module cpu8_arith_flag_unit (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [3:0] req_cmd,
   input  logic [7:0] req_acc,
   input  logic [7:0] req_index_x,
   input  logic [7:0] req_index_y,
   input  logic [7:0] req_operand,
   input  logic       req_carry_flag,
   input  logic       req_decimal_mode,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_reg_value,
   output logic [1:0] rsp_reg_target,
   output logic [7:0] rsp_mem_value,
   output logic       rsp_mem_write,
   output logic       rsp_flag_n,
   output logic       rsp_flag_z,
   output logic       rsp_flag_c,
   output logic       rsp_flag_v,
   output logic [3:0] rsp_flag_mask
);
   import cafu_pkg::*;

   logic       prep_valid;
   logic       prep_stall;
   prep_type   prep_data;
   logic       sum_valid;
   logic       sum_stall;
   sum_type    sum_data;
   result_type result;

   // Stage one decodes the operation and forms the read-modify-write byte, the adder
   // operands and the result of the purely logical operations.
   cafu_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_stall     (req_stall),
      .cmd          (req_cmd),
      .acc          (req_acc),
      .index_x      (req_index_x),
      .index_y      (req_index_y),
      .operand      (req_operand),
      .carry_flag   (req_carry_flag),
      .decimal_mode (req_decimal_mode),
      .out_valid    (prep_valid),
      .out_stall    (prep_stall),
      .out_data     (prep_data)
   );

   // Stage two runs the binary adder, shared by add, subtract and compare, and forms
   // the per-digit partial sums that decimal mode needs.
   cafu_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_stall  (prep_stall),
      .in_data   (prep_data),
      .out_valid (sum_valid),
      .out_stall (sum_stall),
      .out_data  (sum_data)
   );

   // Stage three applies the decimal corrections, selects the flags and masks them;
   // its register is the response register.
   cafu_flags u_flags (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_stall  (sum_stall),
      .in_data   (sum_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (result)
   );

   assign rsp_reg_value  = result.reg_value;
   assign rsp_reg_target = result.reg_target;
   assign rsp_mem_value  = result.mem_value;
   assign rsp_mem_write  = result.mem_write;
   assign rsp_flag_n     = result.flag_n;
   assign rsp_flag_z     = result.flag_z;
   assign rsp_flag_c     = result.flag_c;
   assign rsp_flag_v     = result.flag_v;
   assign rsp_flag_mask  = result.flag_mask;

   // A decoded item held by a stall in the adder stage must still be there next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (prep_valid && prep_stall) |=> prep_valid)
      else $error("decode stage lost an item while stalled");

   // An item in the adder stage that the flag stage takes must appear at the response.
   assert property (@(posedge clock) disable iff (reset)
      (sum_valid && !sum_stall) |=> rsp_valid)
      else $error("item taken by the flag stage did not reach the response");

   // A response without a destination register carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_reg_target == TGT_NONE)) |-> (rsp_reg_value == 8'h00))
      else $error("register value not zero without a destination");

   // Memory write-back only comes with a flag mask that updates N and Z.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mem_write) |-> (rsp_flag_mask[MASK_BIT_N] && rsp_flag_mask[MASK_BIT_Z]))
      else $error("memory write-back without an N and Z update");

endmodule

FILE: rtl/cafu_prep.sv
// Decode stage: operation decode, read-modify-write byte and adder operands.
`timescale 1ns / 1ps

module cafu_prep (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  logic [3:0]          cmd,
   input  logic [7:0]          acc,
   input  logic [7:0]          index_x,
   input  logic [7:0]          index_y,
   input  logic [7:0]          operand,
   input  logic                carry_flag,
   input  logic                decimal_mode,
   output logic                out_valid,
   input  logic                out_stall,
   output cafu_pkg::prep_type  out_data
);
   import cafu_pkg::*;

   logic     valid_ff;
   prep_type data_ff;
   prep_type data_in;
   logic     load;

   assign in_stall  = valid_ff & out_stall;
   assign load      = ~in_stall;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      logic [7:0] and_am;
      and_am = acc & operand;

      data_in           = '0;
      data_in.tgt       = TGT_NONE;
      data_in.mask      = MASK_NONE;
      data_in.cin_orig  = carry_flag;
      data_in.alu_a     = acc;
      data_in.alu_b     = operand;
      data_in.alu_cin   = carry_flag;

      case (cmd_type'(cmd))
         CMD_ADC: begin
            data_in.use_alu = 1'b1;
            data_in.dec     = decimal_mode;
            data_in.tgt     = TGT_ACC;
            data_in.mask    = MASK_NZCV;
         end
         CMD_SBC: begin
            data_in.use_alu = 1'b1;
            data_in.sub     = 1'b1;
            data_in.dec     = decimal_mode;
            data_in.tgt     = TGT_ACC;
            data_in.mask    = MASK_NZCV;
         end
         CMD_CMP, CMD_CPX, CMD_CPY: begin
            data_in.use_alu = 1'b1;
            data_in.sub     = 1'b1;
            data_in.alu_cin = 1'b1;
            data_in.mask    = MASK_NZC;
            if (cmd_type'(cmd) == CMD_CPX) begin
               data_in.alu_a = index_x;
            end else if (cmd_type'(cmd) == CMD_CPY) begin
               data_in.alu_a = index_y;
            end
         end
         CMD_ANC: begin
            data_in.logic_val = and_am;
            data_in.logic_c   = and_am[7];
            data_in.tgt       = TGT_ACC;
            data_in.mask      = MASK_NZC;
         end
         CMD_ARR: begin
            data_in.logic_val = {carry_flag, and_am[7:1]};
            data_in.tgt       = TGT_ACC;
            data_in.mask      = MASK_NZ;
         end
         CMD_ASR: begin
            data_in.logic_val = {1'b0, and_am[7:1]};
            data_in.logic_c   = and_am[0];
            data_in.tgt       = TGT_ACC;
            data_in.mask      = MASK_NZC;
         end
         CMD_SBX: begin
            data_in.use_alu = 1'b1;
            data_in.sub     = 1'b1;
            data_in.alu_a   = acc & index_x;
            data_in.alu_cin = 1'b1;
            data_in.tgt     = TGT_X;
            data_in.mask    = MASK_NZ;
         end
         CMD_DCP: begin
            data_in.mem_val = operand - 8'd1;
            data_in.mem_wr  = 1'b1;
            data_in.use_alu = 1'b1;
            data_in.sub     = 1'b1;
            data_in.alu_b   = operand - 8'd1;
            data_in.alu_cin = 1'b1;
            data_in.mask    = MASK_NZC;
         end
         CMD_ISC: begin
            data_in.mem_val = operand + 8'd1;
            data_in.mem_wr  = 1'b1;
            data_in.use_alu = 1'b1;
            data_in.sub     = 1'b1;
            data_in.dec     = decimal_mode;
            data_in.alu_b   = operand + 8'd1;
            data_in.tgt     = TGT_ACC;
            data_in.mask    = MASK_NZCV;
         end
         CMD_RLA: begin
            data_in.mem_val   = {operand[6:0], carry_flag};
            data_in.mem_wr    = 1'b1;
            data_in.logic_val = {operand[6:0], carry_flag} & acc;
            data_in.logic_c   = operand[7];
            data_in.tgt       = TGT_ACC;
            data_in.mask      = MASK_NZC;
         end
         CMD_RRA: begin
            // The bit rotated out of the byte becomes the carry into the add.
            data_in.mem_val = {carry_flag, operand[7:1]};
            data_in.mem_wr  = 1'b1;
            data_in.use_alu = 1'b1;
            data_in.dec     = decimal_mode;
            data_in.alu_b   = {carry_flag, operand[7:1]};
            data_in.alu_cin = operand[0];
            data_in.tgt     = TGT_ACC;
            data_in.mask    = MASK_NZCV;
         end
         CMD_SLO: begin
            data_in.mem_val   = {operand[6:0], 1'b0};
            data_in.mem_wr    = 1'b1;
            data_in.logic_val = {operand[6:0], 1'b0} | acc;
            data_in.logic_c   = operand[7];
            data_in.tgt       = TGT_ACC;
            data_in.mask      = MASK_NZC;
         end
         CMD_SRE: begin
            data_in.mem_val   = {1'b0, operand[7:1]};
            data_in.mem_wr    = 1'b1;
            data_in.logic_val = {1'b0, operand[7:1]} ^ acc;
            data_in.logic_c   = operand[0];
            data_in.tgt       = TGT_ACC;
            data_in.mask      = MASK_NZC;
         end
         default: begin
            data_in.tgt  = TGT_NONE;
            data_in.mask = MASK_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: rtl/cafu_sum.sv
// Adder stage: binary sum or difference and the BCD digit partial sums.
`timescale 1ns / 1ps

module cafu_sum (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  cafu_pkg::prep_type  in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output cafu_pkg::sum_type   out_data
);
   import cafu_pkg::*;

   logic    valid_ff;
   sum_type data_ff;
   sum_type data_in;
   logic    load;

   assign in_stall  = valid_ff & out_stall;
   assign load      = ~in_stall;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      logic [7:0] b_eff;
      // Subtraction is an add of the inverted operand with carry as not-borrow.
      b_eff = in_data.sub ? ~in_data.alu_b : in_data.alu_b;

      data_in.bin     = {1'b0, in_data.alu_a} + {1'b0, b_eff} + {8'b0, in_data.alu_cin};
      data_in.v_bin   = (in_data.alu_a[7] ^ data_in.bin[7]) & (b_eff[7] ^ data_in.bin[7]);
      data_in.x7      = in_data.alu_a[7];
      data_in.y7      = in_data.alu_b[7];
      data_in.lo_sum  = {1'b0, in_data.alu_a[3:0]} + {1'b0, in_data.alu_b[3:0]}
                        + {4'b0, in_data.alu_cin};
      data_in.hi_sum  = {1'b0, in_data.alu_a[7:4]} + {1'b0, in_data.alu_b[7:4]};
      data_in.lo_diff = {2'b0, in_data.alu_a[3:0]} - {2'b0, in_data.alu_b[3:0]}
                        - {5'b0, ~in_data.alu_cin};
      data_in.hi_diff = {2'b0, in_data.alu_a[7:4], 4'b0} - {2'b0, in_data.alu_b[7:4], 4'b0};

      data_in.dec       = in_data.dec;
      data_in.sub       = in_data.sub;
      data_in.use_alu   = in_data.use_alu;
      data_in.logic_val = in_data.logic_val;
      data_in.logic_c   = in_data.logic_c;
      data_in.tgt       = in_data.tgt;
      data_in.mem_val   = in_data.mem_val;
      data_in.mem_wr    = in_data.mem_wr;
      data_in.mask      = in_data.mask;
      data_in.cin_orig  = in_data.cin_orig;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: rtl/cafu_flags.sv
// Flag stage: BCD fix-ups, flag selection, masking and the result register.
`timescale 1ns / 1ps

module cafu_flags (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  cafu_pkg::sum_type    in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output cafu_pkg::result_type out_data
);
   import cafu_pkg::*;

   logic       valid_ff;
   result_type data_ff;
   result_type data_in;
   logic       load;

   assign in_stall  = valid_ff & out_stall;
   assign load      = ~in_stall;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      logic [7:0] val;
      logic       n;
      logic       z;
      logic       c;
      logic       v;
      logic [4:0] lo_adj;
      logic [4:0] hi_inc;
      logic [4:0] hi_adj;
      logic [7:0] mid;
      logic [5:0] t_adj;
      logic [5:0] t_fix;
      logic [9:0] res;

      lo_adj = in_data.lo_sum + BCD_ADJ5;
      hi_inc = in_data.hi_sum;
      if (in_data.lo_sum >= BCD_LIMIT) begin
         hi_inc = in_data.hi_sum + 5'd1;
      end
      mid    = {hi_inc[3:0], (in_data.lo_sum >= BCD_LIMIT) ? lo_adj[3:0] : in_data.lo_sum[3:0]};
      hi_adj = hi_inc + BCD_ADJ5;

      t_adj = in_data.lo_diff - BCD_ADJ6;
      t_fix = in_data.lo_diff[5] ? {2'b11, t_adj[3:0]} : in_data.lo_diff;
      res   = in_data.hi_diff + {{4{t_fix[5]}}, t_fix};

      if (!in_data.use_alu) begin
         val = in_data.logic_val;
         n   = val[7];
         z   = (val == 8'h00);
         c   = in_data.logic_c;
         v   = 1'b0;
      end else if (!in_data.dec) begin
         val = in_data.bin[7:0];
         n   = val[7];
         z   = (val == 8'h00);
         c   = in_data.bin[8];
         v   = in_data.v_bin;
      end else if (!in_data.sub) begin
         // Decimal add: Z from the binary sum, N and V from the half-adjusted sum.
         z   = (in_data.bin[7:0] == 8'h00);
         n   = mid[7];
         v   = (in_data.x7 ^ mid[7]) & (in_data.y7 ^ mid[7]);
         c   = (hi_inc >= BCD_LIMIT);
         val = {c ? hi_adj[3:0] : hi_inc[3:0], mid[3:0]};
      end else begin
         // Decimal subtract: N, Z and V come from the binary difference.
         n   = in_data.bin[7];
         z   = (in_data.bin[7:0] == 8'h00);
         v   = in_data.v_bin;
         c   = ~res[9];
         val = res[9] ? (res[7:0] - BCD_HI_ADJ) : res[7:0];
      end

      data_in.reg_value  = (in_data.tgt == TGT_NONE) ? 8'h00 : val;
      data_in.reg_target = in_data.tgt;
      data_in.mem_value  = in_data.mem_wr ? in_data.mem_val : 8'h00;
      data_in.mem_write  = in_data.mem_wr;
      data_in.flag_n     = n & in_data.mask[MASK_BIT_N];
      data_in.flag_z     = z & in_data.mask[MASK_BIT_Z];
      data_in.flag_c     = in_data.mask[MASK_BIT_C] ? c : in_data.cin_orig;
      data_in.flag_v     = v & in_data.mask[MASK_BIT_V];
      data_in.flag_mask  = in_data.mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
